@@ hdl/dhnt_pkg.sv @@
// Shared types and constants for the double-hashed name table.
`default_nettype none
package dhnt_pkg;

  localparam int MODE_W    = 2;
  localparam int WORD_W    = 64;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 10;
  localparam int PROBE_W   = 11;
  localparam int SIZE_W    = 11;
  localparam int CNT_W     = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int REM_W     = 18;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BAD    = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_LIMIT     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_DELETED   = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND  = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd6;
  localparam logic [STATUS_W-1:0] STAT_INVALID   = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_MIN        = 11'd3;
  localparam logic [SIZE_W-1:0] SIZE_RESET      = 11'd1021;
  localparam logic [CNT_W-1:0]  MAX_RESET       = 11'd1024;
  localparam logic [CNT_W-1:0]  COUNT_MAX       = 11'd2047;
  localparam logic [REM_W-1:0]  HASH_MUL        = 18'd31;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_HASH_A,
    S_HASH_B,
    S_STEP,
    S_ISSUE,
    S_CHECK,
    S_DONE
  } dhnt_state_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic decode;
    logic hash_a;
    logic hash_b;
    logic set_step;
    logic check;
    logic out_load;
  } dhnt_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic invalid;
    logic limit;
    logic last_byte;
    logic hit;
    logic exhausted;
    logic out_free;
  } dhnt_stat_t;

endpackage
`default_nettype wire

@@ hdl/double_hash_name_table.sv @@
// Top level of the double-hashed name table.
//
//  channel | direction | beat contents
//  in_     | in        | mode, name_word0..3
//  out_    | out       | status, slot, probes
//  cfg_    | in        | index 0 table_size, index 1 max_entries
//
// A request is decoded, then hashed one name byte at a time (HASH_A,
// HASH_B), given its probe step and probed slot by slot (ISSUE, CHECK)
// until a hit or exhaustion; invalid and limit answers skip hashing and
// probing. Each probe uses the RAM read port. After reset a clearing pass
// wipes the slot flags before the first beat is taken. A finished result
// waits in the output register while the next beat is taken; out_stall then holds it.
`default_nettype none
module double_hash_name_table #(
  parameter int TABLE_DEPTH = 1024,
  parameter int NAME_BYTES  = 30
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dhnt_pkg::MODE_W-1:0]        in_mode,
  input  logic [dhnt_pkg::WORD_W-1:0]        in_name_word0,
  input  logic [dhnt_pkg::WORD_W-1:0]        in_name_word1,
  input  logic [dhnt_pkg::WORD_W-1:0]        in_name_word2,
  input  logic [dhnt_pkg::WORD_W-1:0]        in_name_word3,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dhnt_pkg::STATUS_W-1:0]      out_status,
  output logic [dhnt_pkg::SLOT_W-1:0]        out_slot,
  output logic [dhnt_pkg::PROBE_W-1:0]       out_probes,
  input  logic                               cfg_we,
  input  logic [dhnt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dhnt_pkg::CFG_W-1:0]         cfg_wdata
);
  import dhnt_pkg::*;

  dhnt_cmd_t  cmd;
  dhnt_stat_t stat;
  logic       in_ready;

  assign in_stall = ~in_ready;

  dhnt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dhnt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NAME_BYTES  (NAME_BYTES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_mode       (in_mode),
    .in_name_word0 (in_name_word0),
    .in_name_word1 (in_name_word1),
    .in_name_word2 (in_name_word2),
    .in_name_word3 (in_name_word3),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_slot      (out_slot),
    .out_probes    (out_probes)
  );

endmodule
`default_nettype wire

@@ hdl/dhnt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dhnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hdl/dhnt_ctrl.sv @@
// Request sequencer: clearing pass, hashing, probing and result handoff.
`default_nettype none
module dhnt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dhnt_pkg::dhnt_stat_t stat,
  output dhnt_pkg::dhnt_cmd_t  cmd
);
  import dhnt_pkg::*;

  dhnt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.invalid || stat.limit) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_HASH_A;
        end
      end
      S_HASH_A: begin
        cmd.hash_a = 1'b1;
        state_nxt  = S_HASH_B;
      end
      S_HASH_B: begin
        cmd.hash_b = 1'b1;
        state_nxt  = stat.last_byte ? S_STEP : S_HASH_A;
      end
      S_STEP: begin
        cmd.set_step = 1'b1;
        state_nxt    = S_ISSUE;
      end
      S_ISSUE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.hit || stat.exhausted) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/dhnt_dpath.sv @@
// Datapath: name capture, Horner hash, double-hash probe and table storage.
`default_nettype none
module dhnt_dpath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int NAME_BYTES  = 30
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dhnt_pkg::dhnt_cmd_t                cmd,
  output dhnt_pkg::dhnt_stat_t               stat,
  input  logic [dhnt_pkg::MODE_W-1:0]        in_mode,
  input  logic [dhnt_pkg::WORD_W-1:0]        in_name_word0,
  input  logic [dhnt_pkg::WORD_W-1:0]        in_name_word1,
  input  logic [dhnt_pkg::WORD_W-1:0]        in_name_word2,
  input  logic [dhnt_pkg::WORD_W-1:0]        in_name_word3,
  input  logic                               cfg_we,
  input  logic [dhnt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dhnt_pkg::CFG_W-1:0]         cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dhnt_pkg::STATUS_W-1:0]      out_status,
  output logic [dhnt_pkg::SLOT_W-1:0]        out_slot,
  output logic [dhnt_pkg::PROBE_W-1:0]       out_probes
);
  import dhnt_pkg::*;

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int KEEP   = NAME_BYTES - 1;
  localparam int NW     = 8 * KEEP;
  localparam int LW     = $clog2(NAME_BYTES);
  localparam int IN_W   = 4 * WORD_W;

  // configuration
  logic [SIZE_W-1:0] tsize_r;
  logic [CNT_W-1:0]  maxe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= SIZE_RESET;
      maxe_r  <= MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_SIZE:  tsize_r <= cfg_wdata;
        REG_MAX_ENTRIES: maxe_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] size_c;
  always_comb begin
    if (tsize_r < SIZE_MIN) begin
      size_c = SIZE_MIN;
    end else if (32'(tsize_r) > TABLE_DEPTH) begin
      size_c = SIZE_W'(TABLE_DEPTH);
    end else begin
      size_c = tsize_r;
    end
  end

  // name capture: keep bytes up to the terminator or the length cap
  logic [IN_W-1:0] in_all;
  logic [NW-1:0]   name_c;
  logic [LW-1:0]   len_c;
  logic            live;

  assign in_all = {in_name_word3, in_name_word2, in_name_word1, in_name_word0};

  always_comb begin
    live   = 1'b1;
    name_c = '0;
    len_c  = '0;
    for (int b = 0; b < KEEP; b++) begin
      if (in_all[8*b +: 8] == 8'd0) begin
        live = 1'b0;
      end
      if (live) begin
        name_c[8*b +: 8] = in_all[8*b +: 8];
        len_c            = LW'(b + 1);
      end
    end
  end

  logic [MODE_W-1:0] mode_r;
  logic [NW-1:0]     name_r;
  logic [LW-1:0]     len_r;
  logic [LW-1:0]     bcnt_r;
  logic [SIZE_W-1:0] h_r;
  logic [REM_W-1:0]  rem_r;
  logic [SIZE_W-1:0] step_r;
  logic [SIZE_W-1:0] idx_r;
  logic [PROBE_W-1:0] pcnt_r;
  logic [CNT_W-1:0]  count_r;
  logic [AW-1:0]     clr_r;

  logic [STATUS_W-1:0] res_status_r;
  logic [SLOT_W-1:0]   res_slot_r;
  logic [PROBE_W-1:0]  res_probes_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [PROBE_W-1:0]  out_probes_r;
  logic                out_valid_r;

  // hash: h*31+byte, then reduce by restoring subtraction split over the HASH_A and HASH_B states
  logic [7:0]       byte_c;
  logic [REM_W-1:0] rem_a_c;
  logic [REM_W-1:0] rem_b_c;

  assign byte_c = name_r[8*bcnt_r +: 8];

  always_comb begin
    rem_a_c = REM_W'(h_r) * HASH_MUL + REM_W'(byte_c);
    for (int k = 6; k >= 3; k--) begin
      if (rem_a_c >= (REM_W'(size_c) << k)) begin
        rem_a_c = rem_a_c - (REM_W'(size_c) << k);
      end
    end
    rem_b_c = rem_r;
    for (int k = 2; k >= 0; k--) begin
      if (rem_b_c >= (REM_W'(size_c) << k)) begin
        rem_b_c = rem_b_c - (REM_W'(size_c) << k);
      end
    end
  end

  // step = 1 + h mod (size-2); h < size so two subtracts suffice
  logic [SIZE_W-1:0] div2_c;
  logic [SIZE_W-1:0] hmod_c;
  always_comb begin
    div2_c = size_c - SIZE_W'(2);
    hmod_c = h_r;
    if (hmod_c >= div2_c) begin
      hmod_c = hmod_c - div2_c;
    end
    if (hmod_c >= div2_c) begin
      hmod_c = hmod_c - div2_c;
    end
  end

  // storage
  logic [1:0]    flag_q;
  logic [NW-1:0] name_q;
  logic          flag_we;
  logic [AW-1:0] flag_waddr;
  logic [1:0]    flag_wdata;
  logic          name_we;
  logic [AW-1:0] idx_addr;

  assign idx_addr = AW'(idx_r);

  logic slot_live;
  logic hit_c;
  logic exhausted_c;
  logic [PROBE_W-1:0] pcnt_inc;
  logic [SIZE_W:0]    idx_sum;

  assign slot_live   = flag_q[1] & ~flag_q[0];
  assign hit_c       = ~flag_q[1] | flag_q[0] | (name_q == name_r);
  assign pcnt_inc    = pcnt_r + PROBE_W'(1);
  assign exhausted_c = (pcnt_inc == PROBE_W'(size_c));
  assign idx_sum     = {1'b0, idx_r} + {1'b0, step_r};

  always_comb begin
    flag_we    = 1'b0;
    flag_waddr = idx_addr;
    flag_wdata = 2'b00;
    name_we    = 1'b0;
    if (cmd.clear_wr) begin
      flag_we    = 1'b1;
      flag_waddr = clr_r;
    end else if (cmd.check && hit_c) begin
      if (mode_r == MODE_INSERT && !slot_live) begin
        flag_we    = 1'b1;
        flag_wdata = 2'b10;
        name_we    = 1'b1;
      end else if (mode_r == MODE_DELETE && slot_live) begin
        flag_we    = 1'b1;
        flag_wdata = 2'b11;
      end
    end
  end

  dhnt_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .raddr (idx_addr),
    .rdata (flag_q)
  );

  dhnt_ram #(.WIDTH(NW), .DEPTH(TABLE_DEPTH)) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (idx_addr),
    .wdata (name_r),
    .raddr (idx_addr),
    .rdata (name_q)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_wr) begin
        clr_r <= clr_r + AW'(1);
      end
      if (name_we && count_r != COUNT_MAX) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      name_r <= name_c;
      len_r  <= len_c;
      bcnt_r <= '0;
      h_r    <= '0;
    end
    if (cmd.decode) begin
      res_slot_r   <= '0;
      res_probes_r <= '0;
      res_status_r <= (mode_r == MODE_BAD || len_r == '0) ? STAT_INVALID : STAT_LIMIT;
    end
    if (cmd.hash_a) begin
      rem_r <= rem_a_c;
    end
    if (cmd.hash_b) begin
      h_r    <= SIZE_W'(rem_b_c);
      bcnt_r <= bcnt_r + LW'(1);
    end
    if (cmd.set_step) begin
      step_r <= hmod_c + SIZE_W'(1);
      idx_r  <= h_r;
      pcnt_r <= '0;
    end
    if (cmd.check) begin
      pcnt_r <= pcnt_inc;
      if (hit_c) begin
        res_probes_r <= pcnt_inc;
        res_slot_r   <= slot_live || mode_r == MODE_INSERT ? SLOT_W'(idx_r) : '0;
        case (mode_r)
          MODE_INSERT: res_status_r <= slot_live ? STAT_DUPLICATE : STAT_INSERTED;
          MODE_DELETE: res_status_r <= slot_live ? STAT_DELETED : STAT_NOTFOUND;
          default:     res_status_r <= slot_live ? STAT_FOUND : STAT_NOTFOUND;
        endcase
      end else begin
        // advance the probe modulo the size
        if (idx_sum >= {1'b0, size_c}) begin
          idx_r <= SIZE_W'(idx_sum - {1'b0, size_c});
        end else begin
          idx_r <= SIZE_W'(idx_sum);
        end
        if (exhausted_c) begin
          res_probes_r <= PROBE_W'(size_c);
          res_slot_r   <= '0;
          res_status_r <= (mode_r == MODE_INSERT) ? STAT_FULL : STAT_NOTFOUND;
        end
      end
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_probes_r <= res_probes_r;
    end
  end

  assign stat.clear_done = (clr_r == AW'(TABLE_DEPTH - 1));
  assign stat.invalid    = (mode_r == MODE_BAD) || (len_r == '0);
  assign stat.limit      = (mode_r == MODE_INSERT) && (count_r >= maxe_r);
  assign stat.last_byte  = (bcnt_r == len_r - LW'(1));
  assign stat.hit        = hit_c;
  assign stat.exhausted  = exhausted_c;
  assign stat.out_free   = ~out_valid_r | ~out_stall;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_probes = out_probes_r;

endmodule
`default_nettype wire

@@ dv/tb_double_hash_name_table.sv @@
// Testbench for the double-hashed name table: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_double_hash_name_table;
  import dhnt_pkg::*;

  localparam int DEPTH     = 1024;
  localparam int NAME_MAX  = 29;
  localparam int POOL_N    = 16;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode = MODE_INSERT;
  logic [WORD_W-1:0]   in_name_word0 = '0;
  logic [WORD_W-1:0]   in_name_word1 = '0;
  logic [WORD_W-1:0]   in_name_word2 = '0;
  logic [WORD_W-1:0]   in_name_word3 = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [PROBE_W-1:0]  out_probes;
  logic                cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TABLE_SIZE;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  double_hash_name_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_name_word0(in_name_word0), .in_name_word1(in_name_word1),
    .in_name_word2(in_name_word2), .in_name_word3(in_name_word3),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_slot(out_slot), .out_probes(out_probes),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [PROBE_W-1:0]  probes;
  } answer_t;

  // Predicted table contents
  logic [SIZE_W-1:0] tbl_size_reg;
  logic [CNT_W-1:0]  max_entries_reg;
  logic [CNT_W-1:0]  live_count;
  logic              used_q [DEPTH];
  logic              tomb_q [DEPTH];
  logic [255:0]      stored_name [DEPTH];

  answer_t answer_q[$];
  int      mismatches = 0;
  int      unexpected = 0;
  int      reqs_sent = 0;
  int      answers_seen = 0;
  int      status_hits[8];
  int      send_idle = 0;
  int      recv_idle = 0;
  int      hold_start = 0;
  int      hold_left = 0;

  logic [255:0] name_pool [POOL_N];

  function automatic answer_t lookup_name(logic [MODE_W-1:0] mode, logic [255:0] raw);
    answer_t      a;
    logic [255:0] nm;
    int           sz, h, len, step, idx, i, b;
    logic [7:0]   by;
    logic         live, hit;
    a = '0;
    sz = tbl_size_reg;
    if (sz < 3) sz = 3;
    if (sz > DEPTH) sz = DEPTH;
    nm = '0;
    h = 0;
    len = 0;
    live = 1'b1;
    for (b = 0; b < 32; b++) begin
      by = raw[8*b +: 8];
      if (by == 8'd0 || b >= NAME_MAX) live = 1'b0;
      if (live) begin
        nm[8*b +: 8] = by;
        h = (h * 31 + by) % sz;
        len++;
      end
    end
    if (mode == MODE_BAD || len == 0) begin
      a.status = STAT_INVALID;
      return a;
    end
    if (mode == MODE_INSERT && live_count >= max_entries_reg) begin
      a.status = STAT_LIMIT;
      return a;
    end
    step = 1 + h % (sz - 2);
    idx = h;
    hit = 1'b0;
    for (i = 0; i < sz; i++) begin
      if (!used_q[idx] || tomb_q[idx] || stored_name[idx] == nm) begin
        hit = 1'b1;
        break;
      end
      idx += step;
      if (idx >= sz) idx -= sz;
    end
    if (!hit) begin
      a.status = (mode == MODE_INSERT) ? STAT_FULL : STAT_NOTFOUND;
      a.probes = PROBE_W'(sz);
      return a;
    end
    live = used_q[idx] && !tomb_q[idx];
    a.probes = PROBE_W'(i + 1);
    if (mode == MODE_INSERT) begin
      a.slot = SLOT_W'(idx);
      if (live) a.status = STAT_DUPLICATE;
      else begin
        stored_name[idx] = nm;
        used_q[idx] = 1'b1;
        tomb_q[idx] = 1'b0;
        if (live_count < COUNT_MAX) live_count++;
        a.status = STAT_INSERTED;
      end
    end else if (live) begin
      a.slot = SLOT_W'(idx);
      if (mode == MODE_DELETE) begin
        tomb_q[idx] = 1'b1;
        a.status = STAT_DELETED;
      end else a.status = STAT_FOUND;
    end else a.status = STAT_NOTFOUND;
    return a;
  endfunction

  // Clean name of len bytes; bytes past it are zero
  function automatic logic [255:0] fresh_name(int len);
    logic [255:0] v;
    v = '0;
    for (int b = 0; b < len; b++) v[8*b +: 8] = 8'($urandom_range(255, 1));
    return v;
  endfunction

  // Fill the bytes past the name with junk the block must ignore
  function automatic logic [255:0] add_junk(logic [255:0] v);
    int len;
    len = 0;
    while (len < NAME_MAX && v[8*len +: 8] != 8'd0) len++;
    for (int b = len + 1; b < 32; b++) v[8*b +: 8] = 8'($urandom_range(255));
    if (len == NAME_MAX) v[8*NAME_MAX +: 8] = 8'($urandom_range(255));
    return v;
  endfunction

  // Noise beats: empty names in any mode
  function automatic logic [MODE_W-1:0] MODE_MODE_PICK(int r);
    return MODE_W'(r);
  endfunction

  task automatic send_req(logic [MODE_W-1:0] mode, logic [255:0] raw);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_name_word0 <= raw[63:0];
    in_name_word1 <= raw[127:64];
    in_name_word2 <= raw[191:128];
    in_name_word3 <= raw[255:192];
    do @(posedge clk); while (in_stall);
    answer_q.push_back(lookup_name(mode, raw));
    reqs_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_TABLE_SIZE) tbl_size_reg = CFG_W'(value);
    else max_entries_reg = CFG_W'(value);
  endtask

  task automatic test_directed;
    logic [255:0] a, b, full, ones;
    write_reg(REG_TABLE_SIZE, 7);
    a = fresh_name(5);
    b = fresh_name(12);
    full = fresh_name(NAME_MAX);
    ones = {256{1'b1}};
    send_req(MODE_BAD, add_junk(a));
    send_req(MODE_INSERT, 256'(0) | (ones << 8));   // empty name, junk after
    send_req(MODE_SEARCH, add_junk(a));
    send_req(MODE_INSERT, add_junk(a));
    send_req(MODE_INSERT, add_junk(a));
    send_req(MODE_SEARCH, a);
    send_req(MODE_DELETE, a);
    send_req(MODE_SEARCH, a);                       // stops on the tombstone
    send_req(MODE_DELETE, a);
    send_req(MODE_INSERT, a);                       // reuse the tombstone
    send_req(MODE_INSERT, add_junk(full));
    send_req(MODE_SEARCH, add_junk(full));
    send_req(MODE_INSERT, ones);                    // all ones, truncated at 29 bytes
    send_req(MODE_SEARCH, full | (ones << 8*NAME_MAX));
    send_req(MODE_INSERT, b);
    for (int i = 0; i < 4; i++) send_req(MODE_INSERT, fresh_name(1 + i));
    send_req(MODE_INSERT, fresh_name(7));           // table full
    send_req(MODE_SEARCH, fresh_name(3));           // probe runs out
    send_req(MODE_DELETE, fresh_name(9));
    drain();
  endtask

  task automatic test_config_extremes;
    logic [255:0] n;
    write_reg(REG_TABLE_SIZE, 0);                   // acts as 3
    for (int i = 0; i < 5; i++) send_req(MODE_INSERT, add_junk(fresh_name(1 + i)));
    write_reg(REG_TABLE_SIZE, 2047);                // acts as full depth
    n = fresh_name(8);
    send_req(MODE_INSERT, n);
    send_req(MODE_SEARCH, add_junk(n));
    write_reg(REG_MAX_ENTRIES, 0);
    send_req(MODE_INSERT, fresh_name(4));
    send_req(MODE_SEARCH, n);
    send_req(MODE_DELETE, n);
    send_req(MODE_INSERT, n);
    write_reg(REG_MAX_ENTRIES, 2047);
    send_req(MODE_INSERT, n);
    write_reg(REG_TABLE_SIZE, 1024);
    send_req(MODE_SEARCH, n);
    drain();
  endtask

  task automatic run_random(int n_items, int sz, int max_e);
    int pick, r, len;
    logic [MODE_W-1:0] m;
    write_reg(REG_TABLE_SIZE, sz);
    write_reg(REG_MAX_ENTRIES, max_e);
    for (int i = 0; i < POOL_N; i++) begin
      len = ($urandom_range(9) == 0) ? NAME_MAX : $urandom_range(NAME_MAX, 1);
      name_pool[i] = fresh_name(len);
    end
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(POOL_N - 1);
      r = $urandom_range(99);
      if (r < 45) m = MODE_INSERT;
      else if (r < 65) m = MODE_DELETE;
      else if (r < 93) m = MODE_SEARCH;
      else m = MODE_BAD;
      if (r >= 96) send_req(MODE_MODE_PICK(r), {$urandom, $urandom, $urandom, $urandom,
                                                $urandom, $urandom, $urandom, 8'($urandom), 24'h0} >> 0);
      else send_req(m, $urandom_range(1) ? add_junk(name_pool[pick]) : name_pool[pick]);
    end
  endtask

  task automatic test_random(int idle_send, int idle_recv);
    send_idle = idle_send;
    recv_idle = idle_recv;
    run_random(75, 13, 10);
    run_random(75, 3 + 2 * $urandom_range(1), 2047);
    run_random(75, 61, $urandom_range(40, 5));
    run_random(75, 1021, 1024);
  endtask

  task automatic test_backpressure;
    send_idle = 0;
    recv_idle = 0;
    write_reg(REG_TABLE_SIZE, 31);
    hold_start = 400;
    for (int i = 0; i < 20; i++) send_req(MODE_SEARCH, fresh_name($urandom_range(6, 1)));
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_start > 0) begin
      hold_left = hold_start;
      hold_start = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      answers_seen++;
      if (answer_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected beat: status %0d slot %0d probes %0d",
                   out_status, out_slot, out_probes);
      end else begin
        want = answer_q.pop_front();
        status_hits[want.status]++;
        if (out_status !== want.status || out_slot !== want.slot ||
            out_probes !== want.probes) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch: expected status %0d slot %0d probes %0d, got %0d %0d %0d",
                     want.status, want.slot, want.probes, out_status, out_slot, out_probes);
        end
      end
    end
  end

  initial begin
    #60ms;
    $display("timeout with %0d answers outstanding", answer_q.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    tbl_size_reg    = SIZE_RESET;
    max_entries_reg = MAX_RESET;
    live_count      = '0;
    for (int i = 0; i < DEPTH; i++) begin
      used_q[i] = 1'b0;
      tomb_q[i] = 1'b0;
      stored_name[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random(11, 48);
    test_random(48, 11);
    test_random(0, 0);
    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d requests, %0d answers over sizes 3..1024 and limits 0..2047",
             reqs_sent, answers_seen);
    $display("status mix: ins %0d dup %0d lim %0d full %0d del %0d nf %0d found %0d inv %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5], status_hits[6], status_hits[7]);
    if (mismatches == 0 && unexpected == 0 && answer_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
